[sv/oma_pkg.sv]
// Shared constants and tables for the orientation matrix to angles unit.
// No dependencies.
package oma_pkg;

  localparam int INPUT_WIDTH_DEF   = 16;
  localparam int CORDIC_STAGES_DEF = 16;

  localparam int DP_W  = 36;
  localparam int ANG_W = 26;
  localparam int RZ_W  = ANG_W - 7;
  localparam int ATAN_LEN = 32;

  localparam logic signed [ANG_W-1:0] DEG180 = ANG_W'(180 * 32768);
  localparam logic [29:0] INV_GAIN_Q30 = 30'd652032874;

  localparam int OUT_FULL    = 46080;
  localparam int OUT_HALF    = 23040;
  localparam int OUT_QUARTER = 11520;

  localparam logic signed [ANG_W-1:0] ATAN_TAB [ATAN_LEN] = '{
    26'sd1474560, 26'sd870484, 26'sd459940, 26'sd233473,
    26'sd117189,  26'sd58653,  26'sd29333,  26'sd14667,
    26'sd7334,    26'sd3667,   26'sd1833,   26'sd917,
    26'sd458,     26'sd229,    26'sd115,    26'sd57,
    26'sd29,      26'sd14,     26'sd7,      26'sd4,
    26'sd2,       26'sd1,      26'sd0,      26'sd0,
    26'sd0,       26'sd0,      26'sd0,      26'sd0,
    26'sd0,       26'sd0,      26'sd0,      26'sd0
  };

endpackage

[sv/orientation_matrix_to_angles_unit.sv]
// Top level of the orientation matrix to angles unit.
// Uses oma_pkg, oma_cordic, oma_gain, oma_wrap.
// Takes one item per cycle while the output is not stalled; each item goes through
// the azimuth CORDIC, the gain multiply and the inclination/roll CORDICs in
// series. The whole pipeline advances whenever the output register is empty
// or being taken, so a stall holds every stage in place.
module orientation_matrix_to_angles_unit import oma_pkg::*; #(
  parameter int INPUT_WIDTH   = INPUT_WIDTH_DEF,
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // east_y, north_y, up_y, up_x, up_z
  input  logic [((5*INPUT_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // azimuth[15:0], inclination[30:16], roll[46:31]
  output logic [47:0] m_axis_tdata
);

  localparam int IW = INPUT_WIDTH;
  localparam int SW = 2 + 3 * IW;
  localparam int SHIFT = 32 - IW;

  logic en;
  logic [IW-1:0] east_y, north_y, up_y, up_x, up_z;
  logic signed [DP_W-1:0] e_s, n_s;
  logic [SW-1:0] side1_in, side1_out;
  logic v1, vg, v2, v3;
  logic signed [ANG_W-1:0] z1, z2, z3;
  logic signed [DP_W-1:0] m1, x2, y2, x3, y3;
  logic [15:0] azimuth;
  logic signed [14:0] inclination;
  logic signed [15:0] roll;

  assign en = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  assign east_y  = s_axis_tdata[IW-1:0];
  assign north_y = s_axis_tdata[2*IW-1:IW];
  assign up_y    = s_axis_tdata[3*IW-1:2*IW];
  assign up_x    = s_axis_tdata[4*IW-1:3*IW];
  assign up_z    = s_axis_tdata[5*IW-1:4*IW];

  assign e_s = {{(DP_W-IW){east_y[IW-1]}}, east_y} <<< SHIFT;
  assign n_s = {{(DP_W-IW){north_y[IW-1]}}, north_y} <<< SHIFT;

  assign side1_in = {north_y[IW-1], (north_y == '0) && (east_y != '0), up_y, up_x, up_z};

  oma_cordic #(.STAGES(CORDIC_STAGES), .SIDE_W(SW)) u_cordic_az (
    .clk, .rst, .en,
    .in_valid(s_axis_tvalid), .x_in(n_s), .y_in(e_s), .side_in(side1_in),
    .out_valid(v1), .z_out(z1), .mag_out(m1), .side_out(side1_out)
  );

  oma_gain #(.INPUT_WIDTH(INPUT_WIDTH)) u_gain (
    .clk, .rst, .en,
    .in_valid(v1), .mag(m1), .side_in(side1_out),
    .out_valid(vg), .x2, .y2, .x3, .y3
  );

  logic signed [ANG_W-1:0] z1_d [CORDIC_STAGES+4];
  always_ff @(posedge clk) begin
    if (en) begin
      z1_d[0] <= z1;
      for (int k = 1; k < CORDIC_STAGES + 4; k++) begin
        z1_d[k] <= z1_d[k-1];
      end
    end
  end

  oma_cordic #(.STAGES(CORDIC_STAGES), .SIDE_W(1)) u_cordic_inc (
    .clk, .rst, .en,
    .in_valid(vg), .x_in(x2), .y_in(y2), .side_in(1'b0),
    .out_valid(v2), .z_out(z2), .mag_out(), .side_out()
  );

  oma_cordic #(.STAGES(CORDIC_STAGES), .SIDE_W(1)) u_cordic_roll (
    .clk, .rst, .en,
    .in_valid(vg), .x_in(x3), .y_in(y3), .side_in(1'b0),
    .out_valid(v3), .z_out(z3), .mag_out(), .side_out()
  );

  oma_wrap u_wrap (
    .clk, .rst, .en,
    .in_valid(v2 && v3), .z1(z1_d[CORDIC_STAGES+3]), .z2, .z3,
    .out_valid(m_axis_tvalid), .azimuth, .inclination, .roll
  );

  assign m_axis_tdata = {1'b0, roll, inclination, azimuth};

endmodule

[sv/oma_cordic.sv]
// Pipelined vectoring CORDIC: one register stage per iteration plus a
// quadrant stage. Uses oma_pkg.
module oma_cordic import oma_pkg::*; #(
  parameter int STAGES = CORDIC_STAGES_DEF,
  parameter int SIDE_W = 1
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  logic                    in_valid,
  input  logic signed [DP_W-1:0]  x_in,
  input  logic signed [DP_W-1:0]  y_in,
  input  logic [SIDE_W-1:0]       side_in,
  output logic                    out_valid,
  output logic signed [ANG_W-1:0] z_out,
  output logic signed [DP_W-1:0]  mag_out,
  output logic [SIDE_W-1:0]       side_out
);

  logic signed [DP_W-1:0]  x     [STAGES+1];
  logic signed [DP_W-1:0]  y     [STAGES+1];
  logic signed [ANG_W-1:0] z     [STAGES+1];
  logic                    zero  [STAGES+1];
  logic [SIDE_W-1:0]       side  [STAGES+1];
  logic                    valid [STAGES+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid[0] <= 1'b0;
    end else if (en) begin
      valid[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      zero[0] <= (x_in == '0) && (y_in == '0);
      side[0] <= side_in;
      if (x_in < 0) begin
        x[0] <= -x_in;
        y[0] <= -y_in;
        z[0] <= (y_in >= 0) ? DEG180 : -DEG180;
      end else begin
        x[0] <= x_in;
        y[0] <= y_in;
        z[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    always_ff @(posedge clk) begin
      if (rst) begin
        valid[i+1] <= 1'b0;
      end else if (en) begin
        valid[i+1] <= valid[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        zero[i+1] <= zero[i];
        side[i+1] <= side[i];
        if (y[i] >= 0) begin
          x[i+1] <= x[i] + (y[i] >>> i);
          y[i+1] <= y[i] - (x[i] >>> i);
          z[i+1] <= z[i] + ATAN_TAB[i];
        end else begin
          x[i+1] <= x[i] - (y[i] >>> i);
          y[i+1] <= y[i] + (x[i] >>> i);
          z[i+1] <= z[i] - ATAN_TAB[i];
        end
      end
    end
  end

  assign out_valid = valid[STAGES];
  assign z_out     = zero[STAGES] ? '0 : z[STAGES];
  assign mag_out   = zero[STAGES] ? '0 : x[STAGES];
  assign side_out  = side[STAGES];

endmodule

[sv/oma_gain.sv]
// Gain removal on the first magnitude (split multiply, round) and operand
// setup for the inclination and roll CORDICs. Uses oma_pkg.
module oma_gain import oma_pkg::*; #(
  parameter int INPUT_WIDTH = INPUT_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic signed [DP_W-1:0]     mag,
  input  logic [2+3*INPUT_WIDTH-1:0] side_in,
  output logic                       out_valid,
  output logic signed [DP_W-1:0]     x2,
  output logic signed [DP_W-1:0]     y2,
  output logic signed [DP_W-1:0]     x3,
  output logic signed [DP_W-1:0]     y3
);

  localparam int SW = 2 + 3 * INPUT_WIDTH;
  localparam int SHIFT = 32 - INPUT_WIDTH;

  logic [46:0]   prod_hi;
  logic [45:0]   prod_lo;
  logic [SW-1:0] side_a, side_b;
  logic [65:0]   sum;
  logic signed [DP_W-1:0] r;
  logic valid_a, valid_b;

  logic signed [DP_W-1:0] uy_s, ux_s, uz_s;
  logic n_neg, y_kill;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a   <= 1'b0;
      valid_b   <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      valid_a   <= in_valid;
      valid_b   <= valid_a;
      out_valid <= valid_b;
    end
  end

  assign sum = 66'({prod_hi, 16'b0}) + 66'(prod_lo) + 66'(1) * (66'(1) << 29);

  always_ff @(posedge clk) begin
    if (en) begin
      prod_hi <= 47'(mag[32:16]) * 47'(INV_GAIN_Q30);
      prod_lo <= 46'(mag[15:0]) * 46'(INV_GAIN_Q30);
      side_a  <= side_in;
      r       <= sum[30+DP_W-1:30];
      side_b  <= side_a;
    end
  end

  assign n_neg  = side_b[SW-1];
  assign y_kill = side_b[SW-2];
  assign uy_s = {{(DP_W-INPUT_WIDTH){side_b[3*INPUT_WIDTH-1]}},
                 side_b[3*INPUT_WIDTH-1:2*INPUT_WIDTH]} <<< SHIFT;
  assign ux_s = {{(DP_W-INPUT_WIDTH){side_b[2*INPUT_WIDTH-1]}},
                 side_b[2*INPUT_WIDTH-1:INPUT_WIDTH]} <<< SHIFT;
  assign uz_s = {{(DP_W-INPUT_WIDTH){side_b[INPUT_WIDTH-1]}},
                 side_b[INPUT_WIDTH-1:0]} <<< SHIFT;

  // north_y zero with east_y nonzero: zero vector, so the angle is exactly 0
  always_ff @(posedge clk) begin
    if (en) begin
      x2 <= y_kill ? '0 : (n_neg ? -r : r);
      y2 <= y_kill ? '0 : (n_neg ? -uy_s : uy_s);
      x3 <= uz_s;
      y3 <= -ux_s;
    end
  end

endmodule

[sv/oma_wrap.sv]
// Output stage: rounds the three angles to 1/128 degree, wraps them into
// range and holds the result item. Uses oma_pkg.
module oma_wrap import oma_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  logic                    in_valid,
  input  logic signed [ANG_W-1:0] z1,
  input  logic signed [ANG_W-1:0] z2,
  input  logic signed [ANG_W-1:0] z3,
  output logic                    out_valid,
  output logic [15:0]             azimuth,
  output logic signed [14:0]      inclination,
  output logic signed [15:0]      roll
);

  localparam int AW = RZ_W + 1;
  localparam logic signed [AW-1:0] FULL    = AW'(OUT_FULL);
  localparam logic signed [AW-1:0] HALF    = AW'(OUT_HALF);
  localparam logic signed [AW-1:0] QUARTER = AW'(OUT_QUARTER);

  logic signed [ANG_W:0] t1, t2, t3;
  logic signed [AW-1:0]  r1, r2, r3, az, v, inc, rl;

  assign t1 = (ANG_W+1)'(z1) + (ANG_W+1)'(128);
  assign t2 = (ANG_W+1)'(z2) + (ANG_W+1)'(128);
  assign t3 = (ANG_W+1)'(z3) + (ANG_W+1)'(128);
  assign r1 = AW'($signed(t1[ANG_W:8]));
  assign r2 = AW'($signed(t2[ANG_W:8]));
  assign r3 = AW'($signed(t3[ANG_W:8]));

  always_comb begin
    az = r1;
    if (r1 < 0) begin
      az = r1 + FULL;
    end else if (r1 >= FULL) begin
      az = r1 - FULL;
    end
    v = r2 + QUARTER;
    if (v < -HALF) begin
      v = v + FULL;
    end else if (v < 0) begin
      v = v + HALF;
    end else if (v >= FULL) begin
      v = v - FULL;
    end else if (v >= HALF) begin
      v = v - HALF;
    end
    inc = v - QUARTER;
    rl = r3;
    if (r3 <= -HALF) begin
      rl = r3 + FULL;
    end else if (r3 > HALF) begin
      rl = r3 - FULL;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      azimuth     <= az[15:0];
      inclination <= inc[14:0];
      roll        <= rl[15:0];
    end
  end

endmodule

[sv/oma_checker.sv]
// Port-level checks for orientation_matrix_to_angles_unit, bound to the top.
// No package dependency.
module oma_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata
);

  a_rst_clear: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

  a_ready: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("input ready not tied to output slot");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled item changed");

  a_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[15:0] < 16'd46080)
      && ($signed(m_axis_tdata[46:31]) > -16'sd23040)
      && ($signed(m_axis_tdata[46:31]) <= 16'sd23040)
      && ($signed(m_axis_tdata[30:16]) >= -15'sd11520)
      && ($signed(m_axis_tdata[30:16]) < 15'sd11520))
    else $error("angle out of range");

endmodule

bind orientation_matrix_to_angles_unit oma_checker u_oma_checker (.*);
